// ----- rtl/core/dfw_pkg.sv -----
// Shared types, widths and helpers for the disparity row forward warp.
// Used by the channel interfaces, the line store and the top level.
// No dependencies.
package dfw_pkg;

   // Payload and register widths.
   localparam int PIX_W  = 8;
   localparam int DISP_W = 16;
   localparam int CSR_W  = 12;

   // Default line store depth and the row width after reset.
   localparam int                 MAX_WIDTH_DEF = 2048;
   localparam logic [CSR_W-1:0]   ROW_WIDTH_RST = 12'd2048;

   // Commands from the column control to the line store.
   typedef struct packed {
      logic rd_en;    // read the active bank at the current column
      logic set_en;   // store a scattered pixel in the active bank
      logic clr_en;   // clear the idle bank at the current column
      logic clr_all;  // clearing pass: clear both banks at the sweep address
      logic bank;     // active bank of the current row
   } store_ctrl_type;

   // Last column index for a programmed row width, with the width clamped to [1, max_width].
   function automatic logic [31:0] last_column(input logic [CSR_W-1:0] width,
                                               input int unsigned max_width);
      logic [31:0] w;
      w = 32'(width);
      if (w == 32'd0) begin
         w = 32'd1;
      end
      if (w > 32'(max_width)) begin
         w = 32'(max_width);
      end
      return w - 32'd1;
   endfunction

endpackage

// ----- rtl/core/dfw_req_if.sv -----
// Input channel of the forward warp: source pixel and signed disparity.
// Depends on dfw_pkg for the field widths.
interface dfw_req_if;
   logic                              valid;
   logic                              ready;
   logic        [dfw_pkg::PIX_W-1:0]  pixel_in;
   logic signed [dfw_pkg::DISP_W-1:0] disparity;

   modport source (output valid, pixel_in, disparity, input ready);
   modport sink   (input valid, pixel_in, disparity, output ready);
endinterface

// ----- rtl/core/dfw_rsp_if.sv -----
// Result channel of the forward warp: warped pixel and end-of-row flag.
// Depends on dfw_pkg for the field widths.
interface dfw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [dfw_pkg::PIX_W-1:0] pixel_out;
   logic                      row_end;

   modport source (output valid, pixel_out, row_end, input ready);
   modport sink   (input valid, pixel_out, row_end, output ready);
endinterface

// ----- rtl/core/dfw_line_store.sv -----
// Ping-pong pending line store: two banks of {valid, pixel} entries.
// The active bank takes scattered pixels; the idle bank is cleared column by column.
// Depends on dfw_pkg for the control struct and pixel width.
module dfw_line_store #(
   parameter int DEPTH = dfw_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  dfw_pkg::store_ctrl_type        ctrl,
   input  logic [$clog2(DEPTH)-1:0]       rd_col,
   input  logic [$clog2(DEPTH)-1:0]       set_col,
   input  logic [dfw_pkg::PIX_W-1:0]      set_pix,
   input  logic [$clog2(DEPTH)-1:0]       clr_col,
   output logic                           rd_hit,
   output logic [dfw_pkg::PIX_W-1:0]      rd_pix
);
   localparam int AW = $clog2(DEPTH);
   localparam int EW = dfw_pkg::PIX_W + 1;

   logic [EW-1:0] bank0 [DEPTH];
   logic [EW-1:0] bank1 [DEPTH];

   logic [EW-1:0] rd0_ff;
   logic [EW-1:0] rd1_ff;
   logic          sel_ff;

   logic          we0;
   logic          we1;
   logic [AW-1:0] wa0;
   logic [AW-1:0] wa1;
   logic [EW-1:0] wd0;
   logic [EW-1:0] wd1;

   // Write port of bank 0: clearing pass, scatter when active, scrub when idle.
   always_comb begin
      we0 = 1'b0;
      wa0 = clr_col;
      wd0 = '0;
      if (ctrl.clr_all) begin
         we0 = 1'b1;
      end else if (!ctrl.bank && ctrl.set_en) begin
         we0 = 1'b1;
         wa0 = set_col;
         wd0 = {1'b1, set_pix};
      end else if (ctrl.bank && ctrl.clr_en) begin
         we0 = 1'b1;
      end
   end

   // Write port of bank 1, the mirror image of bank 0.
   always_comb begin
      we1 = 1'b0;
      wa1 = clr_col;
      wd1 = '0;
      if (ctrl.clr_all) begin
         we1 = 1'b1;
      end else if (ctrl.bank && ctrl.set_en) begin
         we1 = 1'b1;
         wa1 = set_col;
         wd1 = {1'b1, set_pix};
      end else if (!ctrl.bank && ctrl.clr_en) begin
         we1 = 1'b1;
      end
   end

   // Bank 0 memory with registered read.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd0_ff <= bank0[rd_col];
      end
      if (we0) begin
         bank0[wa0] <= wd0;
      end
   end

   // Bank 1 memory with registered read.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd1_ff <= bank1[rd_col];
      end
      if (we1) begin
         bank1[wa1] <= wd1;
      end
   end

   // Remember which bank the held read data belongs to.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         sel_ff <= ctrl.bank;
      end
   end

   assign rd_hit = sel_ff ? rd1_ff[EW-1] : rd0_ff[EW-1];
   assign rd_pix = sel_ff ? rd1_ff[EW-2:0] : rd0_ff[EW-2:0];

endmodule

// ----- rtl/core/disparity_row_forward_warp_top.sv -----
// Channel    Direction  Handshake         Payload
// req        in         valid/ready       pixel_in[7:0], disparity[15:0] signed
// rsp        out        valid/ready       pixel_out[7:0], row_end
// csr        in         csr_wr_en         csr_wr_data[11:0] = row_width
//
// One item is accepted per cycle while no clearing pass runs and the output does not stall;
// its result passes the read stage and then the output register before it is offered.
// The rate is set by the single write port of each line store bank: one scatter per item.
// After reset and after every csr write, a clearing pass runs through all MAX_WIDTH
// entries of both banks; req.ready stays low during it.
// When rsp.ready is low the output register and the read stage hold, and req.ready
// drops once both are full.
//
// Top level of the disparity row forward warp. Depends on dfw_pkg, dfw_req_if,
// dfw_rsp_if and dfw_line_store.
module disparity_row_forward_warp_top #(
   parameter int MAX_WIDTH = dfw_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   dfw_req_if.sink                    req,
   dfw_rsp_if.source                  rsp,
   input  logic                       csr_wr_en,
   input  logic [dfw_pkg::CSR_W-1:0]  csr_wr_data
);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int MAG_W  = dfw_pkg::DISP_W - 1;
   localparam int SUM_W  = ((COL_W > MAG_W) ? COL_W : MAG_W) + 1;
   localparam logic [COL_W-1:0] SWEEP_LAST = COL_W'(MAX_WIDTH - 1);
   localparam logic [COL_W-1:0] LAST_RST   =
      COL_W'(dfw_pkg::last_column(dfw_pkg::ROW_WIDTH_RST, MAX_WIDTH));

   // Column control.
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] last_ff, last_in;
   logic             bank_ff, bank_in;
   logic             sweep_ff, sweep_in;
   logic [COL_W-1:0] sweep_addr_ff, sweep_addr_in;

   // Read stage and output register.
   logic                      s1_v_ff, s1_v_in;
   logic [dfw_pkg::PIX_W-1:0] s1_pix_ff;
   logic                      s1_self_ff;
   logic                      s1_end_ff;
   logic                      out_v_ff, out_v_in;
   logic [dfw_pkg::PIX_W-1:0] out_pix_ff;
   logic                      out_end_ff;

   logic                      adv;
   logic                      acc;
   logic [MAG_W-1:0]          dmag;
   logic [SUM_W-1:0]          sum;
   logic [COL_W-1:0]          tgt;
   logic                      self_hit;
   logic                      at_end;
   logic [dfw_pkg::PIX_W-1:0] result;

   dfw_pkg::store_ctrl_type   ctrl;
   logic [COL_W-1:0]          clr_col;
   logic                      rd_hit;
   logic [dfw_pkg::PIX_W-1:0] rd_pix;

   // Handshake: the read stage moves on when the output register is free or taken.
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = !sweep_ff && (!s1_v_ff || adv);
   assign acc       = req.valid && req.ready;

   // Target column: negative disparity lands in place, overflow clamps to the last column.
   assign dmag     = req.disparity[dfw_pkg::DISP_W-1] ? '0 : req.disparity[MAG_W-1:0];
   assign sum      = SUM_W'(col_ff) + SUM_W'(dmag);
   assign tgt      = (sum > SUM_W'(last_ff)) ? last_ff : sum[COL_W-1:0];
   assign self_hit = (tgt == col_ff);
   assign at_end   = (col_ff == last_ff);

   // Line store commands.
   always_comb begin
      ctrl.rd_en   = acc;
      ctrl.set_en  = acc && !self_hit;
      ctrl.clr_en  = acc;
      ctrl.clr_all = sweep_ff;
      ctrl.bank    = bank_ff;
      clr_col      = sweep_ff ? sweep_addr_ff : col_ff;
   end

   dfw_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_col  (col_ff),
      .set_col (tgt),
      .set_pix (req.pixel_in),
      .clr_col (clr_col),
      .rd_hit  (rd_hit),
      .rd_pix  (rd_pix)
   );

   // Next state of the column counter, bank select, width and clearing pass.
   always_comb begin
      col_in        = col_ff;
      bank_in       = bank_ff;
      last_in       = last_ff;
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (csr_wr_en) begin
         col_in        = '0;
         bank_in       = 1'b0;
         last_in       = COL_W'(dfw_pkg::last_column(csr_wr_data, MAX_WIDTH));
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else begin
         if (acc) begin
            col_in  = at_end ? '0 : col_ff + COL_W'(1);
            bank_in = at_end ? !bank_ff : bank_ff;
         end
         if (sweep_ff) begin
            sweep_in      = (sweep_addr_ff != SWEEP_LAST);
            sweep_addr_in = sweep_addr_ff + COL_W'(1);
         end
      end
   end

   // Valid bits of the read stage and the output register.
   always_comb begin
      s1_v_in  = acc ? 1'b1 : (adv ? 1'b0 : s1_v_ff);
      out_v_in = adv ? s1_v_ff : out_v_ff;
   end

   // The pixel for this column: its own pixel if it stays or nothing is pending, else the pending one.
   assign result = (s1_self_ff || !rd_hit) ? s1_pix_ff : rd_pix;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         bank_ff       <= 1'b0;
         last_ff       <= LAST_RST;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         s1_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         col_ff        <= col_in;
         bank_ff       <= bank_in;
         last_ff       <= last_in;
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         s1_v_ff       <= s1_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff  <= req.pixel_in;
         s1_self_ff <= self_hit;
         s1_end_ff  <= at_end;
      end
      if (adv) begin
         out_pix_ff <= result;
         out_end_ff <= s1_end_ff;
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.pixel_out = out_pix_ff;
   assign rsp.row_end   = out_end_ff;

`ifndef ASSERT_OFF
   // A scattered pixel always lands strictly to the right of its source column.
   a_scatter_right: assert property (@(posedge clock) disable iff (reset)
      acc && !self_hit |-> tgt > col_ff)
      else $error("scatter target not right of the current column");

   // The column never runs past the last column of the row.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_ff)
      else $error("column index beyond row width");

   // The last column of a row wraps to column zero and swaps the banks.
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      acc && at_end && !csr_wr_en |=> col_ff == '0 && bank_ff != $past(bank_ff))
      else $error("row end did not wrap the column or swap the banks");

   // A stalled read stage keeps its item, since its read data cannot be refetched.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !adv |=> s1_v_ff && $stable(s1_pix_ff) && $stable(s1_end_ff))
      else $error("read stage lost a stalled item");

   // The clearing pass only ends after its last entry.
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      $fell(sweep_ff) |-> $past(sweep_addr_ff) == SWEEP_LAST)
      else $error("clearing pass ended early");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for disparity_row_forward_warp_top: pixel items with random
// handshake gaps, checked against a built-in forward warp predictor at several row widths.
// Depends on dfw_pkg, dfw_req_if, dfw_rsp_if and the top level of the block.
module testbench;

   localparam int PIX_W         = dfw_pkg::PIX_W;
   localparam int DISP_W        = dfw_pkg::DISP_W;
   localparam int CSR_W         = dfw_pkg::CSR_W;
   localparam int MAX_WIDTH_DEF = dfw_pkg::MAX_WIDTH_DEF;

   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 130;
   localparam int NUM_PHASES   = 13;
   localparam int RANDOM_WIDTH = -1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             row_end;
   } warped_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [DISP_W-1:0] disp;
      bit                typed;
      logic [PIX_W-1:0]  want_pix;
      bit                want_end;
   } stim_row_type;

   // Directed pixels at a row width of four. Typed rows carry their own expectation.
   stim_row_type directed_rows [20] = '{
      '{8'h00, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0},
      '{8'h12, 16'h7FFF, 1'b1, 8'h12, 1'b0},
      '{8'h34, 16'h0000, 1'b1, 8'h34, 1'b1},
      '{8'hA0, 16'h0002, 1'b0, 8'h00, 1'b0},
      '{8'hA1, 16'h0001, 1'b0, 8'h00, 1'b0},
      '{8'hA2, 16'h0003, 1'b0, 8'h00, 1'b0},
      '{8'hA3, 16'h0000, 1'b1, 8'hA3, 1'b1},
      '{8'hC0, 16'h0003, 1'b0, 8'h00, 1'b0},
      '{8'hC1, 16'h8000, 1'b1, 8'hC1, 1'b0},
      '{8'hC2, 16'h0001, 1'b0, 8'h00, 1'b0},
      '{8'hC3, 16'h5555, 1'b0, 8'h00, 1'b0},
      '{8'h5A, 16'h7FFF, 1'b0, 8'h00, 1'b0},
      '{8'hA5, 16'h2AAA, 1'b0, 8'h00, 1'b0},
      '{8'h0F, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{8'hF0, 16'h1234, 1'b0, 8'h00, 1'b0},
      '{8'h11, 16'h0001, 1'b0, 8'h00, 1'b0},
      '{8'h22, 16'h0001, 1'b0, 8'h00, 1'b0},
      '{8'h33, 16'hFFFB, 1'b0, 8'h00, 1'b0},
      '{8'h44, 16'h0000, 1'b0, 8'h00, 1'b0}
   };

   // Row widths of the random phases; the random entries pick a small width.
   int plan_width [NUM_PHASES] = '{1, 0, 2, 4095, 5, 16, 33, RANDOM_WIDTH, RANDOM_WIDTH,
                                   RANDOM_WIDTH, RANDOM_WIDTH, RANDOM_WIDTH, 2048};

   logic clock;
   logic reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   dfw_req_if req_ch ();
   dfw_rsp_if rsp_ch ();

   disparity_row_forward_warp_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: programmed width, current column and the scattered line.
   logic [CSR_W-1:0] row_width_q;
   int unsigned      warp_col;
   logic [PIX_W-1:0] scatter_pix [MAX_WIDTH_DEF];
   bit               scatter_vld [MAX_WIDTH_DEF];

   warped_type warped_due [$];
   int      mismatches;
   int      items_sent;
   int      results_seen;
   int      cycle_count;
   int      hold_asks;
   int      holds_done;
   bit      no_idle;

   // Forward warp of one pixel: returns the final value of the current column.
   function automatic warped_type forward_warp(input logic [PIX_W-1:0] pix,
                                               input logic [DISP_W-1:0] disp);
      int unsigned width;
      int unsigned last;
      int unsigned shift;
      int unsigned target;
      int unsigned col;
      warped_type  res;
      width = row_width_q;
      if (width == 0) begin
         width = 1;
      end
      if (width > MAX_WIDTH_DEF) begin
         width = MAX_WIDTH_DEF;
      end
      if (warp_col >= width) begin
         warp_col = width - 1;
      end
      col   = warp_col;
      last  = width - 1;
      shift = disp[DISP_W-1] ? 0 : int'(disp);
      target = col + shift;
      if (target > last) begin
         target = last;
      end
      // The pixel's own landing wins; otherwise the latest scatter into this column, else the pixel itself.
      if (target == col || !scatter_vld[col]) begin
         res.pixel_out = pix;
      end else begin
         res.pixel_out = scatter_pix[col];
      end
      if (target != col) begin
         scatter_pix[target] = pix;
         scatter_vld[target] = 1'b1;
      end
      res.row_end = (col == last);
      if (res.row_end) begin
         warp_col = 0;
         scatter_vld = '{default: 1'b0};
      end else begin
         warp_col = col + 1;
      end
      return res;
   endfunction

   // Disparity for a random pixel: mostly within the row so that scatters get read back.
   function automatic logic [DISP_W-1:0] pick_disparity(input int unsigned eff_width);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) begin
         return DISP_W'($urandom_range(0, (eff_width < 40) ? eff_width : 40));
      end else if (roll < 70) begin
         return 16'h8000 | DISP_W'($urandom_range(0, 16'h7FFF));
      end else if (roll < 85) begin
         return DISP_W'($urandom);
      end else begin
         return DISP_W'($urandom_range(0, 3));
      end
   endfunction

   // Offer one item at the falling edge and record its expectation on acceptance.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [DISP_W-1:0] disp,
                             input bit typed, input warped_type want);
      warped_type predicted;
      while (!no_idle && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.pixel_in  <= pix;
      req_ch.disparity <= disp;
      do @(posedge clock); while (!req_ch.ready);
      predicted = forward_warp(pix, disp);
      warped_due.insert(warped_due.size(), typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Wait until the block has drained, then program a new row width.
   task automatic write_width(input logic [CSR_W-1:0] value);
      while (warped_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      row_width_q = value;
      warp_col    = 0;
      scatter_vld = '{default: 1'b0};
   endtask

   // Clock with a period of two units.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, none while no_idle is set, and a long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 25);
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   initial begin
      warped_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (warped_due.size() == 0) begin
               $display("%0t: unexpected result pixel_out=%0h row_end=%0b", $time,
                        rsp_ch.pixel_out, rsp_ch.row_end);
               mismatches++;
            end else begin
               want = warped_due.pop_front();
               if (rsp_ch.pixel_out !== want.pixel_out) begin
                  $display("%0t: pixel_out expected %0h actual %0h", $time,
                           want.pixel_out, rsp_ch.pixel_out);
                  mismatches++;
               end
               if (rsp_ch.row_end !== want.row_end) begin
                  $display("%0t: row_end expected %0b actual %0b", $time,
                           want.row_end, rsp_ch.row_end);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench failed");
      $finish;
   end

   // Stimulus: reset width, directed table, then random phases over several widths.
   initial begin
      int          width;
      int unsigned eff_width;
      warped_type  none;
      none             = '0;
      mismatches       = 0;
      items_sent       = 0;
      results_seen     = 0;
      hold_asks        = 0;
      holds_done       = 0;
      no_idle          = 1'b0;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.pixel_in  = '0;
      req_ch.disparity = '0;
      row_width_q      = dfw_pkg::ROW_WIDTH_RST;
      warp_col         = 0;
      scatter_vld      = '{default: 1'b0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A few pixels at the width left by reset.
      for (int n = 0; n < 40; n++) begin
         send_pixel(PIX_W'($urandom), pick_disparity(MAX_WIDTH_DEF), 1'b0, none);
      end
      req_ch.valid <= 1'b0;

      // Directed table at a row width of four.
      write_width(CSR_W'(4));
      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].pix, directed_rows[i].disp, directed_rows[i].typed,
                    '{directed_rows[i].want_pix, directed_rows[i].want_end});
      end
      req_ch.valid <= 1'b0;

      // Random phases, each at its own row width.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         width = (plan_width[ph] == RANDOM_WIDTH) ? int'($urandom_range(3, 64)) : plan_width[ph];
         write_width(CSR_W'(width));
         eff_width = (width == 0) ? 1 : ((width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width);
         no_idle = (ph == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == 20) begin
               hold_asks++;
            end
            // Halfway through one phase the sender pauses until all results are back.
            if (ph == 7 && n == PHASE_ITEMS / 2) begin
               req_ch.valid <= 1'b0;
               @(negedge clock);
               while (warped_due.size() != 0) begin
                  @(negedge clock);
               end
            end
            send_pixel(PIX_W'($urandom), pick_disparity(eff_width), 1'b0, none);
         end
         req_ch.valid <= 1'b0;
         no_idle = 1'b0;
      end

      // Drain and allow a few more cycles for stray results.
      @(negedge clock);
      while (warped_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(posedge clock);
      $display("Covered %0d pixels at %0d row widths, including zero, one and over the maximum.",
               items_sent, NUM_PHASES + 2);
      $display("Compared %0d warped results in %0d cycles.", results_seen, cycle_count);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
